FILE: hw/rtl/ptrrs_pkg.sv
// Package for the process table round robin scheduler.
// Holds the status codes, action codes, item payload types and the cell control struct.
// No dependencies.
`default_nettype none

package ptrrs_pkg;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_SCHED = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [2:0] ST_UNUSED     = 3'd0;
  localparam logic [2:0] ST_NEW        = 3'd1;
  localparam logic [2:0] ST_RUNNABLE   = 3'd2;
  localparam logic [2:0] ST_WAIT_TASK  = 3'd3;
  localparam logic [2:0] ST_WAIT_PIPE  = 3'd4;
  localparam logic [2:0] ST_WAIT_STDIN = 3'd5;
  localparam logic [2:0] ST_KILLED     = 3'd6;

  // Pipes that can ever report ready; the mask field has 16 bits.
  localparam int NUM_PIPES = 16;
  // Slot, wait target and parent fields are 6 bits wide.
  localparam int IDX_SPAN = 64;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         slot;
    logic [2:0]         new_status;
    logic [5:0]         wait_target;
    logic [5:0]         parent_slot;
    logic signed [31:0] exit_value;
    logic               stdin_ready;
    logic [15:0]        pipe_ready_mask;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         slot_out;
    logic [31:0]        pid_out;
    logic [2:0]         status_out;
    logic signed [31:0] exit_out;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                load;
    logic                run;
    logic                alloc_mode;
    logic                stdin;
    logic [IDX_SPAN-1:0] pipe_rdy;
    logic [IDX_SPAN-1:0] killed;
    logic [IDX_SPAN-1:0] alive;
    logic [2:0]          wr_status;
    logic [5:0]          wr_wait;
    logic [5:0]          wr_parent;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptrrs_in_if.sv
// Input and result channel interfaces of the scheduler.
// Depends on ptrrs_pkg for the payload types.
`default_nettype none

interface ptrrs_in_if;
  logic                valid;
  logic                ready;
  ptrrs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptrrs_out_if;
  logic                 valid;
  logic                 ready;
  ptrrs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/process_table_round_robin_scheduler.sv
// Process table round robin scheduler, top level: one item at a time.
// Allocate and schedule pass a token along the ring of slot cells, one slot per cycle.
// A hit goes to the memory read state, after the exit copy states if it wakes a task
// waiting on another task, then to the result state; a miss goes straight to the result
// state, and write and read go via the memory read state. An item is taken once the last
// one has reached the output register. Synchronous active-low reset clears every slot.
`default_nettype none

module process_table_round_robin_scheduler #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptrrs_in_if.sink    in_ch,
  ptrrs_out_if.source out_ch
);
  import ptrrs_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);

  // Controller states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_COPY1 = 3'd2;
  localparam logic [2:0] S_COPY2 = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LAT   = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;        // slot under the token
  logic [IW-1:0]   cnt_r, cnt_nxt;        // slots visited this pass
  logic [IW-1:0]   cur_r, cur_nxt;        // last scheduled slot
  logic [IW-1:0]   tgt_r, tgt_nxt;        // awaited slot of a woken task
  logic [31:0]     pid_r, pid_nxt;        // next pid to hand out
  logic            alloc_r, alloc_nxt;
  logic            stdin_r, stdin_nxt;
  logic [15:0]     mask_r, mask_nxt;
  logic            em_found_r, em_found_nxt;
  logic            em_zero_r, em_zero_nxt;
  logic [5:0]      em_slot_r, em_slot_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            in_acc;
  logic [IW+5:0]   slot_ext, tgt_ext, idx_ext;
  logic [IW-1:0]   slot_idx, start_idx;
  logic            slot_ok;

  // Cell ring.
  cell_ctl_t       ctl;
  logic [NUM_SLOTS-1:0] tok_v, hit_v, load_v, wr_v;
  logic [2:0]      st_a [NUM_SLOTS];
  logic [5:0]      wt_a [NUM_SLOTS];

  // Pid and exit code memories, with per-entry valid bits standing for the reset zero.
  logic [31:0]     pid_mem [NUM_SLOTS];
  logic [31:0]     ex_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pid_vld_r, ex_vld_r;
  logic [31:0]     pid_rd_r, ex_rd_r;
  logic            pid_rv_r, ex_rv_r;
  logic            pid_we, ex_we, pid_re, ex_re;
  logic [IW-1:0]   pid_wa, ex_wa, pid_ra, ex_ra;
  logic [31:0]     pid_wd, ex_wd;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign slot_ext  = {{IW{1'b0}}, in_ch.data.slot};
  assign slot_idx  = slot_ext[IW-1:0];
  assign slot_ok   = (32'(in_ch.data.slot) < NUM_SLOTS);
  assign tgt_ext   = {{IW{1'b0}}, wt_a[idx_r]};
  assign idx_ext   = {6'b0, idx_r};
  assign start_idx = (in_ch.data.action == ACT_ALLOC) ? '0 :
                     ((32'(cur_r) == NUM_SLOTS - 1) ? '0 : cur_r + 1'b1);

  // Broadcast vectors: per-slot killed/alive, padded to the 6-bit index span.
  genvar g;
  generate
    for (g = 0; g < IDX_SPAN; g++) begin : g_span
      if (g < NUM_SLOTS) begin : g_in
        assign ctl.killed[g] = (st_a[g] == ST_KILLED);
        assign ctl.alive[g]  = (st_a[g] >= ST_NEW) && (st_a[g] <= ST_WAIT_STDIN);
      end else begin : g_out
        assign ctl.killed[g] = 1'b0;
        assign ctl.alive[g]  = 1'b0;
      end
      if (g < NUM_PIPES && g < 16) begin : g_pipe
        assign ctl.pipe_rdy[g] = mask_r[g];
      end else begin : g_nopipe
        assign ctl.pipe_rdy[g] = 1'b0;
      end
    end
  endgenerate

  assign ctl.load       = in_acc && ((in_ch.data.action == ACT_ALLOC) ||
                                     (in_ch.data.action == ACT_SCHED));
  assign ctl.run        = (state_r == S_SCAN);
  assign ctl.alloc_mode = alloc_r;
  assign ctl.stdin      = stdin_r;
  assign ctl.wr_status  = in_ch.data.new_status;
  assign ctl.wr_wait    = in_ch.data.wait_target;
  assign ctl.wr_parent  = in_ch.data.parent_slot;

  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      assign load_v[g] = (start_idx == IW'(g));
      assign wr_v[g]   = in_acc && (in_ch.data.action == ACT_WRITE) && slot_ok &&
                         (slot_idx == IW'(g));
      ptrrs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .load_tok (load_v[g]),
        .tok_prev (tok_v[(g + NUM_SLOTS - 1) % NUM_SLOTS]),
        .wr_sel   (wr_v[g]),
        .tok      (tok_v[g]),
        .hit      (hit_v[g]),
        .status   (st_a[g]),
        .wait_tgt (wt_a[g])
      );
    end
  endgenerate

  // Controller: sequence scan, exit copy, memory read and result load.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    pid_nxt       = pid_r;
    alloc_nxt     = alloc_r;
    stdin_nxt     = stdin_r;
    mask_nxt      = mask_r;
    em_found_nxt  = em_found_r;
    em_zero_nxt   = em_zero_r;
    em_slot_nxt   = em_slot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    pid_we = 1'b0; pid_wa = idx_r; pid_wd = pid_r;
    ex_we  = 1'b0; ex_wa  = idx_r; ex_wd  = '0;
    pid_re = 1'b0; pid_ra = idx_r;
    ex_re  = 1'b0; ex_ra  = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          stdin_nxt = in_ch.data.stdin_ready;
          mask_nxt  = in_ch.data.pipe_ready_mask;
          alloc_nxt = (in_ch.data.action == ACT_ALLOC);
          idx_nxt   = start_idx;
          cnt_nxt   = '0;
          if ((in_ch.data.action == ACT_ALLOC) || (in_ch.data.action == ACT_SCHED)) begin
            state_nxt = S_SCAN;
          end else begin
            // Write or read: show the slot as it stands after the write.
            if ((in_ch.data.action == ACT_WRITE) && slot_ok) begin
              ex_we = 1'b1;
              ex_wa = slot_idx;
              ex_wd = in_ch.data.exit_value;
            end
            idx_nxt      = slot_idx;
            em_found_nxt = 1'b0;
            em_zero_nxt  = !slot_ok;
            em_slot_nxt  = in_ch.data.slot;
            state_nxt    = S_RD;
          end
        end
      end
      S_SCAN: begin
        if (|hit_v) begin
          em_found_nxt = 1'b1;
          em_zero_nxt  = 1'b0;
          em_slot_nxt  = idx_ext[5:0];
          if (alloc_r) begin
            pid_we    = 1'b1;
            pid_wd    = pid_r;
            ex_we     = 1'b1;
            ex_wd     = '0;
            pid_nxt   = pid_r + 32'd1;
            state_nxt = S_RD;
          end else begin
            cur_nxt = idx_r;
            if (st_a[idx_r] == ST_WAIT_TASK) begin
              tgt_nxt   = tgt_ext[IW-1:0];
              state_nxt = S_COPY1;
            end else begin
              state_nxt = S_RD;
            end
          end
        end else if (32'(cnt_r) == NUM_SLOTS - 1) begin
          em_found_nxt = 1'b0;
          em_zero_nxt  = 1'b1;
          em_slot_nxt  = '0;
          state_nxt    = S_LAT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = (32'(idx_r) == NUM_SLOTS - 1) ? '0 : idx_r + 1'b1;
        end
      end
      S_COPY1: begin
        ex_re     = 1'b1;
        ex_ra     = tgt_r;
        state_nxt = S_COPY2;
      end
      S_COPY2: begin
        ex_we     = 1'b1;
        ex_wd     = ex_rv_r ? ex_rd_r : '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        pid_re    = 1'b1;
        ex_re     = 1'b1;
        state_nxt = S_LAT;
      end
      S_LAT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.found      = em_found_r;
          out_nxt.slot_out   = em_slot_r;
          out_nxt.pid_out    = (em_zero_r || !pid_rv_r) ? '0 : pid_rd_r;
          out_nxt.status_out = em_zero_r ? ST_UNUSED : st_a[idx_r];
          out_nxt.exit_out   = (em_zero_r || !ex_rv_r) ? '0 : ex_rd_r;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      pid_r       <= '0;
      out_valid_r <= 1'b0;
      pid_vld_r   <= '0;
      ex_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      pid_r       <= pid_nxt;
      out_valid_r <= out_valid_nxt;
      if (pid_we) pid_vld_r[pid_wa] <= 1'b1;
      if (ex_we)  ex_vld_r[ex_wa]   <= 1'b1;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    tgt_r      <= tgt_nxt;
    alloc_r    <= alloc_nxt;
    stdin_r    <= stdin_nxt;
    mask_r     <= mask_nxt;
    em_found_r <= em_found_nxt;
    em_zero_r  <= em_zero_nxt;
    em_slot_r  <= em_slot_nxt;
    out_r      <= out_nxt;
  end

  // Memories: one write and one registered read a cycle each.
  always_ff @(posedge clk) begin
    if (pid_we) pid_mem[pid_wa] <= pid_wd;
    if (pid_re) begin
      pid_rd_r <= pid_mem[pid_ra];
      pid_rv_r <= pid_vld_r[pid_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_we) ex_mem[ex_wa] <= ex_wd;
    if (ex_re) begin
      ex_rd_r <= ex_mem[ex_ra];
      ex_rv_r <= ex_vld_r[ex_ra];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ptrrs_cell.sv
// One slot of the process table: status, wait target, parent and the scan token.
// Depends on ptrrs_pkg.
`default_nettype none

module ptrrs_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ptrrs_pkg::cell_ctl_t ctl,
  input  wire logic                 load_tok,
  input  wire logic                 tok_prev,
  input  wire logic                 wr_sel,
  output logic                      tok,
  output logic                      hit,
  output logic [2:0]                status,
  output logic [5:0]                wait_tgt
);
  import ptrrs_pkg::*;

  logic       tok_r, tok_nxt;
  logic [2:0] st_r, st_nxt;
  logic [5:0] wt_r, wt_nxt;
  logic [5:0] pa_r, pa_nxt;
  logic       on_tok, wake, sched_hit, alloc_hit, free_it;

  always_comb begin
    on_tok    = tok_r & ctl.run;
    wake      = ((st_r == ST_WAIT_TASK) && ctl.killed[wt_r]) ||
                ((st_r == ST_WAIT_STDIN) && ctl.stdin) ||
                ((st_r == ST_WAIT_PIPE) && ctl.pipe_rdy[wt_r]);
    sched_hit = (st_r == ST_NEW) || (st_r == ST_RUNNABLE) || wake;
    alloc_hit = (st_r == ST_UNUSED);
    free_it   = (st_r == ST_KILLED) && !ctl.alive[pa_r];
    hit       = on_tok & (ctl.alloc_mode ? alloc_hit : sched_hit);
  end

  always_comb begin
    tok_nxt = ctl.load ? load_tok : (ctl.run ? tok_prev : tok_r);
    st_nxt  = st_r;
    wt_nxt  = wt_r;
    pa_nxt  = pa_r;
    if (wr_sel) begin
      st_nxt = ctl.wr_status;
      wt_nxt = ctl.wr_wait;
      pa_nxt = ctl.wr_parent;
    end else if (on_tok) begin
      if (ctl.alloc_mode) begin
        if (alloc_hit) begin
          wt_nxt = '0;
          pa_nxt = '0;
        end
      end else if (wake) begin
        st_nxt = ST_RUNNABLE;
      end else if (free_it) begin
        st_nxt = ST_UNUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      st_r  <= ST_UNUSED;
      wt_r  <= '0;
      pa_r  <= '0;
    end else begin
      tok_r <= tok_nxt;
      st_r  <= st_nxt;
      wt_r  <= wt_nxt;
      pa_r  <= pa_nxt;
    end
  end

  assign tok      = tok_r;
  assign status   = st_r;
  assign wait_tgt = wt_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ptrrs_chk.sv
// Port-level assertions for the scheduler, bound to the top level.
// Depends on ptrrs_pkg for status codes.
`default_nettype none

module ptrrs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        found,
  input wire logic [2:0]  status_out,
  input wire logic [31:0] exit_out
);
  import ptrrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |->
      (status_out == ST_UNUSED) || (status_out == ST_NEW) || (status_out == ST_RUNNABLE))
    else $error("found result with a non-runnable status");

  a_alloc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found && (status_out == ST_UNUSED) |-> exit_out == 32'd0)
    else $error("allocated slot keeps an old exit code");

endmodule

bind process_table_round_robin_scheduler ptrrs_chk u_ptrrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .found      (out_ch.data.found),
  .status_out (out_ch.data.status_out),
  .exit_out   (out_ch.data.exit_out)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the process table round robin scheduler: random and directed
// allocate, write, schedule and read items checked against a slot-table predictor.
// Depends on ptrrs_pkg and the ptrrs_in_if / ptrrs_out_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb_top;
  import ptrrs_pkg::*;

  localparam int SLOTS = 64;
  localparam int TIMEOUT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ptrrs_in_if  in_ch ();
  ptrrs_out_if out_ch ();

  process_table_round_robin_scheduler #(.NUM_SLOTS(SLOTS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predictor copy of the process table.
  logic [2:0]  tbl_status [SLOTS];
  logic [31:0] tbl_pid    [SLOTS];
  logic [5:0]  tbl_wait   [SLOTS];
  logic [5:0]  tbl_parent [SLOTS];
  logic [31:0] tbl_exit   [SLOTS];
  logic [5:0]  cur_slot;
  logic [31:0] pid_counter;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("MISMATCH @%0d %s: got %0h expected %0h", cycle_count, what, got, want);
  endtask

  function automatic out_item_t slot_view(input logic found, input logic [5:0] idx);
    out_item_t r;
    r.found = found;
    r.slot_out = idx;
    r.pid_out = tbl_pid[idx];
    r.status_out = tbl_status[idx];
    r.exit_out = tbl_exit[idx];
    return r;
  endfunction

  function automatic logic is_alive(input logic [2:0] s);
    return s >= ST_NEW && s <= ST_WAIT_STDIN;
  endfunction

  // Work out the result of one item and advance the table.
  function automatic out_item_t process_table_step(input in_item_t it);
    out_item_t r;
    logic [5:0] idx;
    logic [2:0] s;
    logic [5:0] t;
    r = '0;
    case (it.action)
      ACT_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_status[i] == ST_UNUSED) begin
            tbl_wait[i] = '0;
            tbl_parent[i] = '0;
            tbl_exit[i] = '0;
            tbl_pid[i] = pid_counter;
            pid_counter = pid_counter + 1;
            return slot_view(1'b1, 6'(i));
          end
        end
      end
      ACT_WRITE, ACT_READ: begin
        if (it.action == ACT_WRITE) begin
          tbl_status[it.slot] = it.new_status;
          tbl_wait[it.slot] = it.wait_target;
          tbl_parent[it.slot] = it.parent_slot;
          tbl_exit[it.slot] = it.exit_value;
        end
        r = slot_view(1'b0, it.slot);
      end
      default: begin
        idx = cur_slot;
        for (int n = 0; n < SLOTS; n++) begin
          idx = idx + 1;
          s = tbl_status[idx];
          t = tbl_wait[idx];
          if (s == ST_NEW || s == ST_RUNNABLE) begin
            cur_slot = idx;
            return slot_view(1'b1, idx);
          end else if (s == ST_WAIT_TASK) begin
            if (tbl_status[t] == ST_KILLED) begin
              tbl_status[idx] = ST_RUNNABLE;
              tbl_exit[idx] = tbl_exit[t];
              cur_slot = idx;
              return slot_view(1'b1, idx);
            end
          end else if (s == ST_WAIT_STDIN) begin
            if (it.stdin_ready) begin
              tbl_status[idx] = ST_RUNNABLE;
              cur_slot = idx;
              return slot_view(1'b1, idx);
            end
          end else if (s == ST_WAIT_PIPE) begin
            // Pipe indexes beyond the mask never become ready.
            if (t < NUM_PIPES && it.pipe_ready_mask[t[3:0]]) begin
              tbl_status[idx] = ST_RUNNABLE;
              cur_slot = idx;
              return slot_view(1'b1, idx);
            end
          end else if (s == ST_KILLED) begin
            // Free a killed slot whose parent is gone.
            if (!is_alive(tbl_status[tbl_parent[idx]])) tbl_status[idx] = ST_UNUSED;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] act, input int slot,
                                         input int st, input int wt, input int par,
                                         input logic [31:0] ev, input logic sr,
                                         input logic [15:0] mask);
    in_item_t it;
    it.action = act;
    it.slot = 6'(slot);
    it.new_status = 3'(st);
    it.wait_target = 6'(wt);
    it.parent_slot = 6'(par);
    it.exit_value = ev;
    it.stdin_ready = sr;
    it.pipe_ready_mask = mask;
    return it;
  endfunction

  // Random item, biased toward small slot ranges so schedules meet live slots.
  function automatic in_item_t random_item();
    int roll;
    int span;
    logic [1:0] act;
    roll = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 63 : 11;
    if (roll < 15) act = ACT_ALLOC;
    else if (roll < 55) act = ACT_WRITE;
    else if (roll < 85) act = ACT_SCHED;
    else act = ACT_READ;
    return make_item(act, $urandom_range(span), $urandom_range(7),
                     ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(span),
                     ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(span),
                     $urandom(), 1'($urandom_range(1)),
                     ($urandom_range(2) == 0) ? 16'($urandom()) : 16'h0);
  endfunction

  // Driver: hold valid and data until the item is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance, in order.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_results.push_back(process_table_step(in_ch.data));
  end

  // Receiver ready: long hold-off counts down in its own process.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.data), 64'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.found !== want.found)
          report_mismatch("found", 64'(out_ch.data.found), 64'(want.found));
        if (out_ch.data.slot_out !== want.slot_out)
          report_mismatch("slot_out", 64'(out_ch.data.slot_out), 64'(want.slot_out));
        if (out_ch.data.pid_out !== want.pid_out)
          report_mismatch("pid_out", 64'(out_ch.data.pid_out), 64'(want.pid_out));
        if (out_ch.data.status_out !== want.status_out)
          report_mismatch("status_out", 64'(out_ch.data.status_out), 64'(want.status_out));
        if (out_ch.data.exit_out !== want.exit_out)
          report_mismatch("exit_out", 64'(out_ch.data.exit_out), 64'(want.exit_out));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait until the queue drains and every result has come back.
  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < count; k++) pending_items.push_back(random_item());
    drain();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_status[i] = ST_UNUSED;
      tbl_pid[i] = '0;
      tbl_wait[i] = '0;
      tbl_parent[i] = '0;
      tbl_exit[i] = '0;
    end
    cur_slot = '0;
    pid_counter = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty schedule, allocs, every status, wakes, frees, extremes.
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 1, 16'hFFFF));
    pending_items.push_back(make_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 63, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 0, ST_RUNNABLE, 63, 63, 32'h7FFFFFFF, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 1, ST_KILLED, 0, 0, 32'h80000000, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 2, ST_WAIT_TASK, 1, 0, 5, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 3, ST_WAIT_STDIN, 0, 0, 7, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 4, ST_WAIT_PIPE, 15, 0, 9, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 5, ST_WAIT_PIPE, 40, 0, 9, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 6, 7, 0, 63, 1, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 7, ST_KILLED, 0, 63, 2, 0, 0));
    pending_items.push_back(make_item(ACT_WRITE, 8, ST_NEW, 0, 0, 32'hFFFFFFFF, 1, 16'h0));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 1, 16'h0));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 16'h8000));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 1, 16'hFFFF));
    pending_items.push_back(make_item(ACT_READ, 7, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++)
      pending_items.push_back(make_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Fill the table so allocate runs out of free slots.
    for (int i = 0; i < SLOTS; i++)
      pending_items.push_back(make_item(ACT_WRITE, i, ST_WAIT_STDIN, 0, 0, i, 0, 0));
    pending_items.push_back(make_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_SCHED, 0, 0, 0, 0, 0, 0, 0));
    drain();

    run_phase(350, 0, 0);
    run_phase(250, 70, 0);
    // Hold the receiver off while the sender keeps offering items.
    hold_off_cycles = 400;
    run_phase(250, 0, 70);
    run_phase(250, 20, 20);
    run_phase(150, 0, 0);

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
